// ----- src/rsfe_pkg.sv -----
`timescale 1ns / 1ps

package rsfe_pkg;

  localparam int DATA_W      = 64;
  localparam int SIZE_W      = 7;
  localparam int DEPTH_OUT_W = 4;

  // Command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_PUSH  = 2'd2,
    CMD_POP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2,
    ST_BAD_SIZE  = 2'd3
  } status_e;

  // Source of the data in the write-back stage
  typedef enum logic [1:0] {
    SRC_REG  = 2'd0,
    SRC_SAVE = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_REQ  = 2'd3
  } wsrc_e;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_DECODE  = 3'd1,
    S_SAVE    = 3'd2,
    S_MOVE_DN = 3'd3,
    S_CLEAR   = 3'd4,
    S_MOVE_UP = 3'd5,
    S_RESTORE = 3'd6,
    S_FINISH  = 3'd7
  } seq_state_e;

  typedef struct packed {
    logic              nat;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [6:0]        reg_index;
    logic [DATA_W-1:0] write_data;
    logic              write_nat;
    logic [SIZE_W-1:0] frame_size;
    logic [SIZE_W-1:0] locals_size;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]      read_data;
    logic                   read_nat;
    logic [1:0]             status;
    logic [SIZE_W-1:0]      new_frame_marker;
    logic [DEPTH_OUT_W-1:0] stack_depth;
  } rsp_t;

endpackage

// ----- src/rsfe_regfile.sv -----
`timescale 1ns / 1ps

module rsfe_regfile #(
  parameter int REG_COUNT = 96
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(REG_COUNT)-1:0] rd_addr_i,
  output rsfe_pkg::entry_t             rd_data_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(REG_COUNT)-1:0] wr_addr_i,
  input  rsfe_pkg::entry_t             wr_data_i
);
  import rsfe_pkg::*;

  entry_t                 mem [REG_COUNT];
  logic   [REG_COUNT-1:0] valid_q;
  entry_t                 rd_q;
  logic                   rd_valid_q;

  // Entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

// ----- src/register_stack_frame_engine_top.sv -----
`timescale 1ns / 1ps

// Register stack frame engine. Holds STACKED_REG_COUNT stacked registers
// (64 data bits plus a NaT bit each) in a one-port-read, one-port-write
// memory, and up to FRAME_STACK_DEPTH saved local areas in a second memory.
// A transaction is taken when start is high and busy is low; its result
// appears on rsp_o with done_o high for exactly one cycle, and must be
// captured then, since the block cannot be stalled. Read and write pass
// through the decode and finish states only. Push walks the decode, save,
// move-down, clear and finish states; pop walks decode, move-up, a restore
// state when a frame is restored, and finish; empty phases are skipped.
// Every move goes one entry per cycle through the single write port of its
// target memory, read in the cycle before its write-back. A push or pop
// with bad sizes, a push on a full stack and read/write transactions go
// straight from decode to finish. A new transaction may be started in the
// same cycle that done_o is high. No clearing pass is needed after reset:
// register entries carry valid bits.
module register_stack_frame_engine_top #(
  parameter int FRAME_STACK_DEPTH = 8,
  parameter int STACKED_REG_COUNT = 96
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rsfe_pkg::req_t req_i,
  output logic           done_o,
  output rsfe_pkg::rsp_t rsp_o
);
  import rsfe_pkg::*;

  localparam int RAW        = $clog2(STACKED_REG_COUNT);
  localparam int SAVE_SLOTS = FRAME_STACK_DEPTH * STACKED_REG_COUNT;
  localparam int SAW        = $clog2(SAVE_SLOTS);
  localparam int CW         = $clog2(FRAME_STACK_DEPTH + 1);

  // Sequencer state
  seq_state_e        state_q, state_d;
  logic [SIZE_W-1:0] cnt_q, cnt_d;
  req_t              req_q;
  logic [SAW-1:0]    base_q, base_d;
  logic [CW-1:0]     count_q, count_d;
  rsp_t              rsp_q, rsp_d;
  logic              done_q;

  // Decode of the held transaction
  cmd_e              cmd;
  logic              idx_ok;
  logic              size_bad;
  logic              stack_full;
  logic              stack_empty;
  logic [SIZE_W-1:0] sol;
  logic [SIZE_W-1:0] nout;
  logic              has_locals;
  logic              has_outs;
  logic              has_restore;
  status_e           status;
  logic [SIZE_W-1:0] phase_len;
  logic              last_step;
  logic [CW-1:0]     frame_idx;
  logic [CW+3:0]     depth_ext;

  // Step addresses
  logic [SIZE_W-1:0] mdn_src;
  logic [SIZE_W-1:0] clr_dst;
  logic [SIZE_W-1:0] mup_src;
  logic [SIZE_W-1:0] mup_dst;

  // Issue stage: read now, write back next cycle
  logic              rf_rd_en;
  logic [RAW-1:0]    rf_rd_addr;
  logic              sv_rd_en;
  logic [SAW-1:0]    sv_rd_addr;
  logic              iss_wr;
  logic              iss_dst_save;
  wsrc_e             iss_src;
  logic [RAW-1:0]    iss_reg_addr;
  logic [SAW-1:0]    iss_save_addr;

  // Write-back stage
  logic              wr_pend_q;
  logic              wr_dst_save_q;
  wsrc_e             wr_src_q;
  logic [RAW-1:0]    wr_reg_addr_q;
  logic [SAW-1:0]    wr_save_addr_q;
  entry_t            wr_data;
  entry_t            rf_rd_data;
  logic              rf_wr_en;

  // Saved local areas
  entry_t            save_mem [SAVE_SLOTS];
  entry_t            sv_rd_q;

  assign cmd         = cmd_e'(req_q.command);
  assign sol         = req_q.locals_size;
  assign nout        = req_q.frame_size - req_q.locals_size;
  assign idx_ok      = req_q.reg_index < SIZE_W'(STACKED_REG_COUNT);
  assign size_bad    = (req_q.locals_size > req_q.frame_size) ||
                       (req_q.frame_size > SIZE_W'(STACKED_REG_COUNT));
  assign stack_full  = count_q == CW'(FRAME_STACK_DEPTH);
  assign stack_empty = count_q == '0;
  assign has_locals  = sol != '0;
  assign has_outs    = nout != '0;
  assign has_restore = has_locals && !stack_empty;

  assign mdn_src = sol + cnt_q;
  assign clr_dst = nout + cnt_q;
  assign mup_src = nout - SIZE_W'(1) - cnt_q;
  assign mup_dst = sol + mup_src;

  // Bad sizes win over the full and empty checks
  always_comb begin
    if (size_bad) begin
      status = ST_BAD_SIZE;
    end else if (cmd == CMD_PUSH) begin
      status = stack_full ? ST_PUSH_FULL : ST_OK;
    end else begin
      status = stack_empty ? ST_POP_EMPTY : ST_OK;
    end
  end

  always_comb begin
    case (state_q)
      S_MOVE_DN, S_MOVE_UP: phase_len = nout;
      default:              phase_len = sol;
    endcase
  end

  assign last_step = cnt_q == (phase_len - SIZE_W'(1));

  // Next state: walk the phases, skip the empty ones
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (cmd)
          CMD_PUSH: begin
            if (size_bad || stack_full) begin
              state_d = S_FINISH;
            end else if (has_locals) begin
              state_d = S_SAVE;
            end else if (has_outs) begin
              state_d = S_MOVE_DN;
            end else begin
              state_d = S_FINISH;
            end
          end
          CMD_POP: begin
            if (size_bad) begin
              state_d = S_FINISH;
            end else if (has_outs) begin
              state_d = S_MOVE_UP;
            end else if (has_restore) begin
              state_d = S_RESTORE;
            end else begin
              state_d = S_FINISH;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_SAVE: begin
        if (last_step) begin
          state_d = has_outs ? S_MOVE_DN : S_CLEAR;
        end
      end
      S_MOVE_DN: begin
        if (last_step) begin
          state_d = has_locals ? S_CLEAR : S_FINISH;
        end
      end
      S_CLEAR: begin
        if (last_step) begin
          state_d = S_FINISH;
        end
      end
      S_MOVE_UP: begin
        if (last_step) begin
          state_d = has_restore ? S_RESTORE : S_FINISH;
        end
      end
      S_RESTORE: begin
        if (last_step) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Restart the step counter on every phase change
  assign cnt_d = (state_d == state_q) ? cnt_q + SIZE_W'(1) : '0;

  // Outputs: memory reads and write-back issue for each step
  always_comb begin
    rf_rd_en      = 1'b0;
    rf_rd_addr    = '0;
    sv_rd_en      = 1'b0;
    sv_rd_addr    = '0;
    iss_wr        = 1'b0;
    iss_dst_save  = 1'b0;
    iss_src       = SRC_REG;
    iss_reg_addr  = '0;
    iss_save_addr = '0;
    case (state_q)
      S_DECODE: begin
        if (cmd == CMD_READ && idx_ok) begin
          rf_rd_en   = 1'b1;
          rf_rd_addr = RAW'(req_q.reg_index);
        end
        if (cmd == CMD_WRITE && idx_ok) begin
          iss_wr       = 1'b1;
          iss_src      = SRC_REQ;
          iss_reg_addr = RAW'(req_q.reg_index);
        end
      end
      S_SAVE: begin
        rf_rd_en      = 1'b1;
        rf_rd_addr    = RAW'(cnt_q);
        iss_wr        = 1'b1;
        iss_dst_save  = 1'b1;
        iss_save_addr = base_q + SAW'(cnt_q);
      end
      S_MOVE_DN: begin
        rf_rd_en     = 1'b1;
        rf_rd_addr   = RAW'(mdn_src);
        iss_wr       = 1'b1;
        iss_reg_addr = RAW'(cnt_q);
      end
      S_CLEAR: begin
        iss_wr       = 1'b1;
        iss_src      = SRC_ZERO;
        iss_reg_addr = RAW'(clr_dst);
      end
      S_MOVE_UP: begin
        rf_rd_en     = 1'b1;
        rf_rd_addr   = RAW'(mup_src);
        iss_wr       = 1'b1;
        iss_reg_addr = RAW'(mup_dst);
      end
      S_RESTORE: begin
        sv_rd_en     = 1'b1;
        sv_rd_addr   = base_q + SAW'(cnt_q);
        iss_wr       = 1'b1;
        iss_src      = SRC_SAVE;
        iss_reg_addr = RAW'(cnt_q);
      end
      default: begin
      end
    endcase
  end

  // Push uses the next free frame, pop the top one
  assign frame_idx = (cmd == CMD_PUSH) ? count_q : count_q - CW'(1);
  assign base_d    = SAW'(SAW'(frame_idx) * SAW'(STACKED_REG_COUNT));

  always_comb begin
    count_d = count_q;
    if (!size_bad && cmd == CMD_PUSH && !stack_full) begin
      count_d = count_q + CW'(1);
    end else if (!size_bad && cmd == CMD_POP && !stack_empty) begin
      count_d = count_q - CW'(1);
    end
  end

  assign depth_ext = {4'b0000, count_d};

  always_comb begin
    rsp_d = '0;
    if (cmd == CMD_READ && idx_ok) begin
      rsp_d.read_data = rf_rd_data.data;
      rsp_d.read_nat  = rf_rd_data.nat;
    end
    if (cmd == CMD_PUSH || cmd == CMD_POP) begin
      rsp_d.status = status;
    end
    if (cmd == CMD_PUSH && status == ST_OK) begin
      rsp_d.new_frame_marker = nout;
    end
    rsp_d.stack_depth = depth_ext[DEPTH_OUT_W-1:0];
  end

  // Write-back data: the memory read issued in the previous cycle, zero or the request data
  always_comb begin
    case (wr_src_q)
      SRC_REG:  wr_data = rf_rd_data;
      SRC_SAVE: wr_data = sv_rd_q;
      SRC_ZERO: wr_data = '0;
      SRC_REQ:  wr_data = '{nat: req_q.write_nat, data: req_q.write_data};
      default:  wr_data = '0;
    endcase
  end

  assign rf_wr_en = wr_pend_q && !wr_dst_save_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      done_q    <= state_q == S_FINISH;
      wr_pend_q <= iss_wr;
      if (state_q == S_FINISH) begin
        count_q <= count_d;
      end
    end
  end

  // Payload registers: hold the transaction, the step target and the result
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    if (state_q == S_DECODE) begin
      base_q <= base_d;
    end
    if (state_q == S_FINISH) begin
      rsp_q <= rsp_d;
    end
    wr_dst_save_q  <= iss_dst_save;
    wr_src_q       <= iss_src;
    wr_reg_addr_q  <= iss_reg_addr;
    wr_save_addr_q <= iss_save_addr;
  end

  always_ff @(posedge clk_i) begin
    if (wr_pend_q && wr_dst_save_q) begin
      save_mem[wr_save_addr_q] <= wr_data;
    end
    if (sv_rd_en) begin
      sv_rd_q <= save_mem[sv_rd_addr];
    end
  end

  rsfe_regfile #(
    .REG_COUNT(STACKED_REG_COUNT)
  ) u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rf_rd_en),
    .rd_addr_i(rf_rd_addr),
    .rd_data_o(rf_rd_data),
    .wr_en_i  (rf_wr_en),
    .wr_addr_i(wr_reg_addr_q),
    .wr_data_i(wr_data)
  );

  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A result is shown only once the sequencer has gone back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result strobe outside idle");

  // Every write-back drains before the sequencer goes idle
  a_wb_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> state_q != S_IDLE)
    else $error("write-back pending in idle");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FRAME_STACK_DEPTH))
    else $error("saved frame count over depth");

  // A full-stack refusal leaves the stack full
  a_full_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.status == ST_PUSH_FULL |-> count_q == CW'(FRAME_STACK_DEPTH))
    else $error("push refused on a stack that is not full");

endmodule
